// ----- sv/mh64a_pkg.sv -----
// Shared types, constants and helpers for the MurmurHash64A engine.
package mh64a_pkg;

  // Mixing multiplier and shift distance of MurmurHash64A
  localparam logic [63:0] MH_MUL = 64'hc6a4a7935bd1e995;
  localparam int unsigned MH_SHIFT = 47;

  // Configuration port geometry: 64-bit registers at byte address 8*i
  localparam int unsigned CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-4:0] REG_SEED = '0;

  // Message sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_K1,
    S_K2,
    S_HMUL,
    S_FIN
  } state_t;

  // Partial product steps of the shared multiplier
  typedef enum logic [1:0] {
    MS_IDLE,
    MS_CROSS_LO,
    MS_CROSS_HI
  } mul_step_t;

  // Request to the shared multiplier
  typedef struct packed {
    logic        go;
    logic [63:0] operand;
  } mul_req_t;

  // Status and result of the shared multiplier
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // Keep the low nb bytes of a word; nb of eight or more keeps all
  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  // First work state of an item once the running hash is set up
  function automatic state_t work_entry(input logic [3:0] nb, input logic fin);
    state_t s;
    if (nb >= 4'd8) begin
      s = S_K1;
    end else if (nb != 4'd0) begin
      s = S_HMUL;
    end else if (fin) begin
      s = S_FIN;
    end else begin
      s = S_IDLE;
    end
    return s;
  endfunction

endpackage

// ----- sv/mh64a_mul.sv -----
// Iterative 64-bit multiply by the MurmurHash64A constant, modulo 2^64.
module mh64a_mul (
  input  logic                clk,
  input  logic                rst,
  input  mh64a_pkg::mul_req_t req,
  output mh64a_pkg::mul_rsp_t rsp
);

  localparam logic [31:0] M_LO = mh64a_pkg::MH_MUL[31:0];
  localparam logic [31:0] M_HI = mh64a_pkg::MH_MUL[63:32];

  mh64a_pkg::mul_step_t step;
  mh64a_pkg::mul_step_t step_next;
  logic [63:0] a;
  logic [63:0] acc;
  logic        done;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] prod;

  // Pick the operand halves for the one shared 32x32 multiplier
  always_comb begin
    step_next = step;
    mx        = req.operand[31:0];
    my        = M_LO;
    case (step)
      mh64a_pkg::MS_IDLE: begin
        if (req.go) begin
          step_next = mh64a_pkg::MS_CROSS_LO;
        end
      end
      mh64a_pkg::MS_CROSS_LO: begin
        mx        = a[31:0];
        my        = M_HI;
        step_next = mh64a_pkg::MS_CROSS_HI;
      end
      mh64a_pkg::MS_CROSS_HI: begin
        mx        = a[63:32];
        my        = M_LO;
        step_next = mh64a_pkg::MS_IDLE;
      end
      default: begin
        step_next = mh64a_pkg::MS_IDLE;
      end
    endcase
  end

  assign prod = 64'(mx) * 64'(my);

  // Advance the step counter and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= mh64a_pkg::MS_IDLE;
      done <= 1'b0;
    end else begin
      step <= step_next;
      done <= (step == mh64a_pkg::MS_CROSS_HI);
    end
  end

  // Accumulate the low product, then the two cross products shifted up
  always_ff @(posedge clk) begin
    case (step)
      mh64a_pkg::MS_IDLE: begin
        if (req.go) begin
          a   <= req.operand;
          acc <= prod;
        end
      end
      mh64a_pkg::MS_CROSS_LO,
      mh64a_pkg::MS_CROSS_HI: begin
        acc <= acc + {prod[31:0], 32'd0};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  assign rsp.busy    = (step != mh64a_pkg::MS_IDLE);
  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ----- sv/murmur_hash_64a_top.sv -----
// Top level of the streaming MurmurHash64A engine: sequencer, state and config port.
//
//  channel  | handshake            | payload
//  request  | req_valid/req_ready  | start_req, length, word, bytes, last
//  result   | res_valid/res_ready  | hash
//  config   | APB psel/penable     | paddr, pwdata, prdata (seed at 0)
//
// Every 64-bit multiply runs on one shared 32x32 multiplier as three partial
// products plus a completion step, so the multiplier sets the rate.
// A request runs one multiply per work state: start adds 1, a full word 3,
// a partial word 1, last 1. req_ready is high only between requests.
// The result sits in an output register; a finishing request waits there
// only while the previous hash is untaken.
// Synchronous reset clears the sequencer, the seed and the running hash.
module murmur_hash_64a_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic                             start_req,
  input  logic [47:0]                      length,
  input  logic [63:0]                      word,
  input  logic [3:0]                       bytes,
  input  logic                             last,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [63:0]                      hash,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mh64a_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready
);

  mh64a_pkg::state_t   state;
  mh64a_pkg::state_t   state_next;
  mh64a_pkg::mul_req_t mreq;
  mh64a_pkg::mul_rsp_t mrsp;

  logic [63:0] seed;
  logic [63:0] running_hash;
  logic [63:0] mixed;
  logic [47:0] item_length;
  logic [63:0] item_word;
  logic [3:0]  item_bytes;
  logic        item_last;
  logic        accept;
  logic        seed_sel;
  logic [63:0] fin_val;

  assign accept   = req_valid && req_ready;
  assign seed_sel = (paddr[mh64a_pkg::CFG_ADDR_W-1:3] == mh64a_pkg::REG_SEED);
  assign fin_val  = mrsp.product ^ (mrsp.product >> mh64a_pkg::MH_SHIFT);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = seed_sel ? seed : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed <= pwdata;
    end
  end

  // Shared multiplier
  mh64a_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mh64a_pkg::S_IDLE: begin
        if (accept) begin
          state_next = start_req ? mh64a_pkg::S_INIT : mh64a_pkg::work_entry(bytes, last);
        end
      end
      mh64a_pkg::S_INIT: begin
        if (mrsp.done) begin
          state_next = mh64a_pkg::work_entry(item_bytes, item_last);
        end
      end
      mh64a_pkg::S_K1: begin
        if (mrsp.done) begin
          state_next = mh64a_pkg::S_K2;
        end
      end
      mh64a_pkg::S_K2: begin
        if (mrsp.done) begin
          state_next = mh64a_pkg::S_HMUL;
        end
      end
      mh64a_pkg::S_HMUL: begin
        if (mrsp.done) begin
          state_next = item_last ? mh64a_pkg::S_FIN : mh64a_pkg::S_IDLE;
        end
      end
      mh64a_pkg::S_FIN: begin
        if (mrsp.done) begin
          state_next = mh64a_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mh64a_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: launch one multiply per work state and steer its operand
  always_comb begin
    req_ready    = 1'b0;
    mreq.go      = 1'b0;
    mreq.operand = running_hash ^ mixed;
    case (state)
      mh64a_pkg::S_IDLE: begin
        req_ready = 1'b1;
      end
      mh64a_pkg::S_INIT: begin
        mreq.go      = !mrsp.busy && !mrsp.done;
        mreq.operand = {16'd0, item_length};
      end
      mh64a_pkg::S_K1: begin
        mreq.go      = !mrsp.busy && !mrsp.done;
        mreq.operand = item_word;
      end
      mh64a_pkg::S_K2: begin
        mreq.go      = !mrsp.busy && !mrsp.done;
        mreq.operand = mixed;
      end
      mh64a_pkg::S_HMUL: begin
        mreq.go      = !mrsp.busy && !mrsp.done;
        mreq.operand = running_hash ^ mixed;
      end
      mh64a_pkg::S_FIN: begin
        // hold the launch while the previous hash is still waiting
        mreq.go      = !mrsp.busy && !mrsp.done && !res_valid;
        mreq.operand = running_hash ^ (running_hash >> mh64a_pkg::MH_SHIFT);
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mh64a_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      item_length <= length;
      item_word   <= word;
      item_bytes  <= bytes;
      item_last   <= last;
    end
  end

  // Word mixing register: masked word on accept, then the mixed word
  always_ff @(posedge clk) begin
    if (accept) begin
      mixed <= word & mh64a_pkg::byte_mask(bytes);
    end else if (mrsp.done && state == mh64a_pkg::S_K1) begin
      mixed <= fin_val;
    end else if (mrsp.done && state == mh64a_pkg::S_K2) begin
      mixed <= mrsp.product;
    end
  end

  // Running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (mrsp.done) begin
      case (state)
        mh64a_pkg::S_INIT: running_hash <= seed ^ mrsp.product;
        mh64a_pkg::S_HMUL: running_hash <= mrsp.product;
        mh64a_pkg::S_FIN:  running_hash <= fin_val;
        default:           running_hash <= running_hash;
      endcase
    end
  end

  // Output register: load the finished hash, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mrsp.done && state == mh64a_pkg::S_FIN) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mrsp.done && state == mh64a_pkg::S_FIN) begin
      hash <= fin_val;
    end
  end

  // A multiply completes only inside a work state
  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state != mh64a_pkg::S_IDLE))
    else $error("multiplier finished outside a work state");

  // No new request while the multiplier is running
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !mrsp.busy && !mrsp.done)
    else $error("request taken while the multiplier is busy");

  // A start request always goes through the seed setup first
  a_start_init: assert property (@(posedge clk) disable iff (rst)
    (accept && start_req) |=> (state == mh64a_pkg::S_INIT))
    else $error("start request skipped the seed setup");

  // A result appears only at the end of finalization
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == mh64a_pkg::S_FIN))
    else $error("result raised outside finalization");

endmodule
